FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, codes and types of the unique value stack.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int SIDX_W = 8;
    localparam int CAP_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 3;
    localparam int POS_W  = 4;
    localparam int OCNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_DUP      = 3'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STS_W-1:0] STS_EMPTY    = 3'd3;
    localparam logic [STS_W-1:0] STS_RANGE    = 3'd4;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_FIND,
        OP_READ,
        OP_RANGE
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_qentry;

    typedef struct packed {
        logic [VAL_W-1:0]  data;
        logic [POS_W-1:0]  position;
        logic              found;
        logic [STS_W-1:0]  status;
        logic [OCNT_W-1:0] count;
    } t_result;

endpackage

FILE: rtl/uvs_front.sv
// ----------------------------------------------------------------------------
// uvs_front
// Accepts input items, holds the capacity register and classifies each item.
// ----------------------------------------------------------------------------
module uvs_front
    import uvs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [SIDX_W-1:0] i_slot_index,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_qentry           o_q_entry,
    output logic [CNT_W-1:0]  o_eff_cap
);

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] eff_cap;
    t_op              op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // capacity clamped to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > DEPTH) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    always_comb begin
        unique case (i_cmd)
            CMD_PUSH: begin
                op = OP_PUSH;
            end
            CMD_POP: begin
                op = OP_POP;
            end
            CMD_FIND: begin
                op = OP_FIND;
            end
            default: begin
                if (int'(i_slot_index) >= int'(eff_cap)) begin
                    op = OP_RANGE;
                end else begin
                    op = OP_READ;
                end
            end
        endcase
    end

    assign o_cfg_ready       = 1'b1;
    assign o_s_axis_tready   = !i_q_full;
    assign o_q_push          = i_s_axis_tvalid && !i_q_full;
    assign o_q_entry.op      = op;
    assign o_q_entry.value   = i_value;
    assign o_q_entry.index   = IDX_W'(i_slot_index);
    assign o_eff_cap         = eff_cap;

endmodule

FILE: rtl/uvs_queue.sv
// ----------------------------------------------------------------------------
// uvs_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module uvs_queue
    import uvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_qentry o_head
);

    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/uvs_back.sv
// ----------------------------------------------------------------------------
// uvs_back
// Executes queued items on the slot store, one slot compare per cycle.
// ----------------------------------------------------------------------------
module uvs_back
    import uvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_qentry          i_q_head,
    output logic             o_q_pop,
    input  logic [CNT_W-1:0] i_eff_cap,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out
);

    logic [VAL_W-1:0] r_slots [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_scan;
    t_state           r_state;
    t_qentry          r_cur;
    logic             r_out_valid;
    t_result          r_out;

    t_state           n_state;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_scan;
    t_qentry          n_cur;
    logic             n_out_valid;
    t_result          n_out;

    logic [IDX_W-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic             hit;
    logic             scan_end;
    logic             done;
    logic             start;
    logic             wr_en;
    logic [CNT_W-1:0] pop_addr;

    assign pop_addr = r_count - 1'b1;

    always_comb begin
        case (r_cur.op)
            OP_POP:  rd_addr = pop_addr[IDX_W-1:0];
            OP_READ: rd_addr = r_cur.index;
            default: rd_addr = r_scan[IDX_W-1:0];
        endcase
    end

    assign rd_data  = r_slots[rd_addr];
    assign hit      = (rd_data == r_cur.value);
    assign scan_end = (r_scan == r_count);
    assign start    = (r_state == S_IDLE) && i_q_valid && !r_out_valid;

    always_comb begin
        unique case (r_cur.op)
            OP_PUSH, OP_FIND: done = scan_end || hit;
            default:          done = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_count     = r_count;
        n_scan      = r_scan;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        o_q_pop     = start;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (start) begin
            n_cur  = i_q_head;
            n_scan = '0;
        end

        if (r_state == S_EXEC) begin
            if (!done) begin
                n_scan = r_scan + 1'b1;
            end else begin
                n_out.data     = '0;
                n_out.position = '0;
                n_out.found    = 1'b0;
                n_out.status   = STS_OK;
                unique case (r_cur.op)
                    OP_PUSH: begin
                        if (!scan_end) begin
                            n_out.status = STS_DUP;
                        end else if (r_count >= i_eff_cap) begin
                            n_out.status = STS_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_out.status = STS_EMPTY;
                        end else begin
                            n_count    = pop_addr;
                            n_out.data = rd_data;
                        end
                    end
                    OP_FIND: begin
                        if (scan_end) begin
                            n_out.status = STS_NOTFOUND;
                        end else begin
                            n_out.found    = 1'b1;
                            n_out.position = POS_W'(r_scan);
                        end
                    end
                    OP_READ: begin
                        n_out.data = rd_data;
                    end
                    OP_RANGE: begin
                        n_out.status = STS_RANGE;
                    end
                endcase
                n_out.count = OCNT_W'(n_count);
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slots[i] <= '0;
            end
        end else if (wr_en) begin
            r_slots[r_count[IDX_W-1:0]] <= r_cur.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/unique_value_stack.sv
// ----------------------------------------------------------------------------
// unique_value_stack
// LIFO stack of signed 32-bit values that rejects duplicate pushes.
//
// channel   dir  handshake                      payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser: cmd[1:0]
//                                               tdata: value, slot_index
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tuser: found, status
//                                               tdata: data, position, count
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_data: capacity
//
// push and find scan the slots from slot 0 upward in the back, stopping at the first
// match or at the count when nothing matches; pop and read use no scan
// the back scan compares one slot per cycle; a 2-entry queue decouples input
// synchronous active-low reset clears the slots, the count and capacity 16
// a held result blocks the back only; input is taken until the queue fills
// the back starts its next item in the cycle after the result is taken
// ----------------------------------------------------------------------------
module unique_value_stack
    import uvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [39:0]      i_s_axis_tdata,  // value[31:0], slot_index[39:32]
    input  logic [1:0]       i_s_axis_tuser,  // cmd[1:0]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // data[31:0], position[35:32], count[40:36]
    output logic [3:0]       o_m_axis_tuser,  // found[0], status[3:1]
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_valid;
    t_qentry          q_entry;
    t_qentry          q_head;
    logic [CNT_W-1:0] eff_cap;
    t_result          res;

    uvs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_cmd           (i_s_axis_tuser),
        .i_value         (i_s_axis_tdata[31:0]),
        .i_slot_index    (i_s_axis_tdata[39:32]),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_entry       (q_entry),
        .o_eff_cap       (eff_cap)
    );

    uvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    uvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_eff_cap   (eff_cap),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (res)
    );

    assign o_m_axis_tdata = {7'd0, res.count, res.position, res.data};
    assign o_m_axis_tuser = {res.status, res.found};

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unique value stack. Commands go in on the
// slave stream with random gaps, results come back on the master stream
// with random stalls. A shadow stack in the bench computes each expected
// result when its item is taken. Each result is compared field by field with
// the oldest expected result. The capacity register is rewritten between
// phases while the stack is idle, including the clamped values 0 and 31.
// ----------------------------------------------------------------------------
module tb;
    import uvs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 2 * (DEPTH + 2) + 8;
    localparam int HOLD_LEN     = 400;
    localparam int MAX_REPORTS  = 60;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [39:0]       s_tdata  = '0;
    logic [CMD_W-1:0]  s_tuser  = '0;
    logic              m_tready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CAP_W-1:0]  cfg_data  = '0;

    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [47:0]       o_m_axis_tdata;
    logic [3:0]        o_m_axis_tuser;
    logic              o_cfg_ready;

    // shadow copy of the stack
    logic [VAL_W-1:0]  shadow_slots [DEPTH];
    int unsigned       shadow_fill;
    logic [CAP_W-1:0]  shadow_cap;
    t_result           expected_q [$];

    logic [VAL_W-1:0]  value_pool [8];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  cfg_writes    = 0;
    int  cycle_count   = 0;
    int  status_hits [6];
    int  hold_requests = 0;
    int  hold_served   = 0;
    bit  input_burst   = 1'b0;
    bit  rx_quiet      = 1'b0;

    unique_value_stack uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned cap_in_effect();
        int unsigned c;
        c = 32'(shadow_cap);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    // lowest live slot holding v, DEPTH when absent
    function automatic int unsigned lowest_match(logic [VAL_W-1:0] v);
        for (int unsigned i = 0; i < shadow_fill && i < DEPTH; i++) begin
            if (shadow_slots[i] == v) return i;
        end
        return DEPTH;
    endfunction

    function automatic t_result stack_apply(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                                            logic [SIDX_W-1:0] idx);
        t_result     r;
        int unsigned hit;
        int unsigned cap;
        r = '0;
        r.status = STS_OK;
        cap = cap_in_effect();
        case (cmd)
            CMD_PUSH: begin
                if (lowest_match(val) < DEPTH) begin
                    r.status = STS_DUP;
                end else if (shadow_fill >= cap) begin
                    r.status = STS_FULL;
                end else begin
                    shadow_slots[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            CMD_POP: begin
                if (shadow_fill == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    shadow_fill--;
                    r.data = shadow_slots[shadow_fill];
                end
            end
            CMD_FIND: begin
                hit = lowest_match(val);
                if (hit < DEPTH) begin
                    r.found    = 1'b1;
                    r.position = hit[POS_W-1:0];
                end else begin
                    r.status = STS_NOTFOUND;
                end
            end
            default: begin
                if (idx >= cap) begin
                    r.status = STS_RANGE;
                end else begin
                    r.data = shadow_slots[idx];
                end
            end
        endcase
        r.count = shadow_fill[OCNT_W-1:0];
        status_hits[r.status]++;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0h actual %0h", field, want, got);
    endtask

    always @(posedge i_clk) begin : check_result
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.data     = o_m_axis_tdata[31:0];
            got.position = o_m_axis_tdata[35:32];
            got.count    = o_m_axis_tdata[40:36];
            got.found    = o_m_axis_tuser[0];
            got.status   = o_m_axis_tuser[3:1];
            results_seen++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result with nothing expected: data %0h status %0d",
                           got.data, got.status);
            end else begin
                want = expected_q.pop_front();
                if (got.data !== want.data)
                    flag_mismatch("data", want.data, got.data);
                if (got.position !== want.position)
                    flag_mismatch("position", want.position, got.position);
                if (got.found !== want.found)
                    flag_mismatch("found", want.found, got.found);
                if (got.status !== want.status)
                    flag_mismatch("status", want.status, got.status);
                if (got.count !== want.count)
                    flag_mismatch("count", want.count, got.count);
            end
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin : rx_driver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
                hold_served++;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                          : $urandom_range(10, 40);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [SIDX_W-1:0] idx);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, val};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_q.push_back(stack_apply(cmd, val, idx));
        items_sent++;
    endtask

    task automatic pause_input(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (input_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                         input logic [SIDX_W-1:0] idx);
        send_item(cmd, val, idx);
        pause_input(pick_gap());
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_results();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_cap = cap;
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return value_pool[$urandom_range(0, 7)];
        if (r < 65 && shadow_fill > 0) return shadow_slots[$urandom_range(0, shadow_fill - 1)];
        return $urandom;
    endfunction

    function automatic logic [SIDX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 80) return SIDX_W'($urandom_range(0, DEPTH + 1));
        return SIDX_W'($urandom_range(0, 255));
    endfunction

    task automatic test_reset_state();
        issue(CMD_POP,  32'h0, 8'd0);
        issue(CMD_FIND, 32'h0, 8'd0);
        issue(CMD_READ, 32'h0, 8'd0);
        issue(CMD_READ, 32'hFFFF_FFFF, 8'd15);
        issue(CMD_READ, 32'h0, 8'd16);
        issue(CMD_READ, 32'h0, 8'd255);
    endtask

    task automatic test_stack_ops();
        issue(CMD_PUSH, 32'h7FFF_FFFF, 8'd0);
        issue(CMD_PUSH, 32'h8000_0000, 8'd0);
        issue(CMD_PUSH, 32'h0000_0000, 8'd0);
        issue(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF);
        issue(CMD_PUSH, 32'h8000_0000, 8'd0);
        issue(CMD_FIND, 32'hFFFF_FFFF, 8'd0);
        issue(CMD_FIND, 32'h7FFF_FFFF, 8'd0);
        issue(CMD_FIND, 32'h1234_5678, 8'd0);
        issue(CMD_POP,  32'h0, 8'd0);
        issue(CMD_READ, 32'h0, 8'd3);
        issue(CMD_POP,  32'h0, 8'd0);
        issue(CMD_POP,  32'h0, 8'd0);
        issue(CMD_POP,  32'h0, 8'd0);
        issue(CMD_POP,  32'h0, 8'd0);
    endtask

    task automatic test_capacity_one();
        write_capacity(5'd1);
        issue(CMD_PUSH, 32'h5555_AAAA, 8'd0);
        issue(CMD_PUSH, 32'hAAAA_5555, 8'd0);
        issue(CMD_PUSH, 32'h5555_AAAA, 8'd0);
        issue(CMD_READ, 32'h0, 8'd1);
        issue(CMD_READ, 32'h0, 8'd0);
        issue(CMD_POP,  32'h0, 8'd0);
    endtask

    task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                     input int push_pct);
        logic [CMD_W-1:0] cmd;
        int r;
        write_capacity(cap);
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                input_burst = ($urandom_range(0, 3) == 0);
                rx_quiet    = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < push_pct) cmd = CMD_PUSH;
            else if (r < push_pct + (100 - push_pct) / 3) cmd = CMD_POP;
            else if (r < push_pct + 2 * (100 - push_pct) / 3) cmd = CMD_FIND;
            else cmd = CMD_READ;
            issue(cmd, pick_value(), pick_index());
        end
        input_burst = 1'b0;
        rx_quiet    = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_requests++;
        input_burst = 1'b1;
        for (int i = 0; i < 16; i++)
            issue(CMD_W'($urandom_range(0, 3)), pick_value(), pick_index());
        input_burst = 1'b0;
        while (hold_served != hold_requests) @(posedge i_clk);
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
        for (int i = 0; i < 6; i++) status_hits[i] = 0;
        for (int i = 0; i < 8; i++) value_pool[i] = '0;
        shadow_fill = 0;
        shadow_cap  = CAP_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_stack_ops();
        test_capacity_one();
        test_random_phase(5'd16, 200, 50);
        test_backpressure();
        test_random_phase(5'd31, 200, 70);
        test_random_phase(5'd3,  200, 40);
        test_random_phase(5'd0,  200, 45);
        test_random_phase(5'd1,  200, 50);
        test_random_phase(5'd8,  200, 55);
        test_random_phase(5'd17, 200, 65);
        test_random_phase(5'd2,  200, 45);
        test_random_phase(5'd16, 200, 55);
        wait_for_results();

        $display("summary: %0d items sent, %0d results checked, %0d capacity writes",
                 items_sent, results_seen, cfg_writes);
        $display("summary: duplicate %0d, full %0d, empty %0d, out of range %0d, not found %0d",
                 status_hits[STS_DUP], status_hits[STS_FULL], status_hits[STS_EMPTY],
                 status_hits[STS_RANGE], status_hits[STS_NOTFOUND]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/uvs_pkg.sv
rtl/uvs_front.sv
rtl/uvs_queue.sv
rtl/uvs_back.sv
rtl/unique_value_stack.sv
sim/tb.sv
